>>> design/mandelbrot_escape_time_core_assert.svh
// Assertion macros for the escape-time core.
// Taken in by the top level with a plain include; no other dependencies.
`ifndef MANDELBROT_ESCAPE_TIME_CORE_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// ante implies cons in the same cycle
`define MET_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// ante implies cons in the next cycle
`define MET_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define MET_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define MET_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

>>> design/met_pkg.sv
// Shared types and constants for the escape-time core.
// Used by met_cell, met_gray and mandelbrot_escape_time_core.
package met_pkg;

   localparam int FRAC_BITS = 28;
   localparam int C_W       = 32;
   // magnitude width of a z component that has not yet escaped (|z| <= 2)
   localparam int MW        = FRAC_BITS + 2;
   localparam int SQW       = 2 * MW;
   localparam int XW        = 2 * (MW + 1);
   // z after one step: |z*z| <= 4 plus the full range of c
   localparam int ZW        = ((FRAC_BITS + 2 > C_W - 1) ? FRAC_BITS + 2 : C_W - 1) + 2;

   localparam int CNT_W     = 16;
   localparam int SCALE_W   = 24;
   localparam int GRAY_W    = 8;
   localparam int PROD_W    = CNT_W + SCALE_W;

   localparam logic [SQW:0]    ESC_LIMIT  = (SQW + 1)'(1) << (2 * FRAC_BITS + 2);
   localparam logic [ZW-1:0]   MAG_BOUND  = ZW'(1) << (FRAC_BITS + 1);
   localparam logic [PROD_W:0] GRAY_BIAS  = (PROD_W + 1)'(66);

   localparam logic [CNT_W-1:0]   MAX_ITER_RESET   = CNT_W'(255);
   localparam logic [SCALE_W-1:0] GRAY_SCALE_RESET = SCALE_W'(65536);

   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam logic REG_MAX_ITER   = 1'b0;
   localparam logic REG_GRAY_SCALE = 1'b1;

   // one pixel travelling round the ring
   typedef struct packed {
      logic                    valid;
      logic                    done;
      logic [CNT_W-1:0]        count;
      logic signed [C_W-1:0]   cr;
      logic signed [C_W-1:0]   ci;
      logic signed [ZW-1:0]    zr;
      logic signed [ZW-1:0]    zi;
   } tok_type;

   // a pixel between the product and update halves of a cell
   typedef struct packed {
      logic                    valid;
      logic                    done;
      logic                    bounded;
      logic [CNT_W-1:0]        count;
      logic signed [C_W-1:0]   cr;
      logic signed [C_W-1:0]   ci;
      logic [SQW-1:0]          sq_r;
      logic [SQW-1:0]          sq_i;
      logic signed [XW-1:0]    zprod;
   } prod_type;

endpackage

>>> design/met_cell.sv
// One cell of the iteration ring: a product stage then an update stage.
// Depends on met_pkg for the token types and fixed-point widths.
module met_cell import met_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [CNT_W-1:0] max_iterations,
   input  tok_type          tok_i,
   output tok_type          tok_o
);

   prod_type prod_ff, prod_in;
   tok_type  tok_ff, tok_in;

   logic [ZW-1:0]         zr_mag, zi_mag;
   logic [SQW:0]          sq_sum;
   logic signed [SQW:0]   re_full, re_sh;
   logic signed [XW:0]    im_full, im_sh;
   logic signed [ZW-1:0]  re_t, im_t, cr_x, ci_x;
   logic                  escape, limit_hit;

   // product half
   always_comb begin
      zr_mag = tok_i.zr[ZW-1] ? ZW'(-tok_i.zr) : ZW'(tok_i.zr);
      zi_mag = tok_i.zi[ZW-1] ? ZW'(-tok_i.zi) : ZW'(tok_i.zi);
      prod_in.valid   = tok_i.valid;
      prod_in.done    = tok_i.done;
      prod_in.count   = tok_i.count;
      prod_in.cr      = tok_i.cr;
      prod_in.ci      = tok_i.ci;
      // outside the bound on either axis means |z|^2 > 4 already
      prod_in.bounded = (zr_mag <= MAG_BOUND) && (zi_mag <= MAG_BOUND);
      prod_in.sq_r    = zr_mag[MW-1:0] * zr_mag[MW-1:0];
      prod_in.sq_i    = zi_mag[MW-1:0] * zi_mag[MW-1:0];
      prod_in.zprod   = $signed(tok_i.zr[MW:0]) * $signed(tok_i.zi[MW:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_ff <= '0;
      end else begin
         prod_ff <= prod_in;
      end
   end

   // update half
   always_comb begin
      sq_sum    = {1'b0, prod_ff.sq_r} + {1'b0, prod_ff.sq_i};
      escape    = !prod_ff.bounded || (sq_sum > ESC_LIMIT);
      limit_hit = prod_ff.count >= max_iterations;
      re_full   = $signed({1'b0, prod_ff.sq_r}) - $signed({1'b0, prod_ff.sq_i});
      im_full   = $signed({prod_ff.zprod, 1'b0});
      re_sh     = re_full >>> FRAC_BITS;
      im_sh     = im_full >>> FRAC_BITS;
      re_t      = re_sh[ZW-1:0];
      im_t      = im_sh[ZW-1:0];
      cr_x      = {{(ZW - C_W){prod_ff.cr[C_W-1]}}, prod_ff.cr};
      ci_x      = {{(ZW - C_W){prod_ff.ci[C_W-1]}}, prod_ff.ci};

      tok_in.valid = prod_ff.valid;
      tok_in.cr    = prod_ff.cr;
      tok_in.ci    = prod_ff.ci;
      tok_in.zr    = re_t + cr_x;
      tok_in.zi    = im_t + ci_x;
      if (prod_ff.done || limit_hit || escape) begin
         tok_in.done  = 1'b1;
         tok_in.count = prod_ff.count;
      end else begin
         tok_in.done  = 1'b0;
         tok_in.count = prod_ff.count + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign tok_o = tok_ff;

endmodule

>>> design/met_gray.sv
// Result stage: scales the step count to a gray level and holds the result.
// Depends on met_pkg for widths and the rounding bias.
module met_gray import met_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [SCALE_W-1:0] gray_scale,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [CNT_W-1:0]   in_count,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [CNT_W-1:0]   rsp_iter_count,
   output logic [GRAY_W-1:0]  rsp_gray_level
);

   logic                prd_valid_ff, prd_valid_in;
   logic [CNT_W-1:0]    prd_count_ff, prd_count_in;
   logic [PROD_W-1:0]   prd_ff, prd_in;
   logic                out_valid_ff, out_valid_in;
   logic [CNT_W-1:0]    out_count_ff, out_count_in;
   logic [GRAY_W-1:0]   out_gray_ff, out_gray_in;
   logic                advance;
   logic [PROD_W:0]     biased;
   logic [PROD_W-16:0]  gray_wide;

   assign advance  = prd_valid_ff && (!out_valid_ff || !rsp_stall);
   assign in_ready = !prd_valid_ff || advance;

   always_comb begin
      prd_valid_in = prd_valid_ff;
      prd_count_in = prd_count_ff;
      prd_in       = prd_ff;
      if (in_valid && in_ready) begin
         prd_valid_in = 1'b1;
         prd_count_in = in_count;
         prd_in       = in_count * gray_scale;
      end else if (advance) begin
         prd_valid_in = 1'b0;
      end
   end

   always_comb begin
      biased    = {1'b0, prd_ff} + GRAY_BIAS;
      gray_wide = biased[PROD_W:16];
      out_valid_in = out_valid_ff;
      out_count_in = out_count_ff;
      out_gray_in  = out_gray_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_count_in = prd_count_ff;
         // saturate
         out_gray_in  = (|gray_wide[PROD_W-16:GRAY_W]) ? '1 : gray_wide[GRAY_W-1:0];
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      prd_count_ff <= prd_count_in;
      prd_ff       <= prd_in;
      out_count_ff <= out_count_in;
      out_gray_ff  <= out_gray_in;
      if (reset) begin
         prd_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         prd_valid_ff <= prd_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_iter_count = out_count_ff;
   assign rsp_gray_level = out_gray_ff;

endmodule

>>> design/mandelbrot_escape_time_core.sv
// Escape-time core: one request at a time circulates a ring of NUM_CELLS cells.
// A step passes both register levels of a cell: multiply, then add and escape test.
// When the pixel is done at the ring tap, met_gray registers the product and then the
// result (wait for the ring tap, then gray scaling); with rsp_stall low the next request
// is taken at the edge that makes the result valid, never while a pixel is in the ring.
// Reset (synchronous) empties the ring and sets max_iterations 255, gray_scale 65536.
module mandelbrot_escape_time_core import met_pkg::*; #(
   parameter int NUM_CELLS = 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [C_W-1:0]    req_c_real,
   input  logic signed [C_W-1:0]    req_c_imag,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [CNT_W-1:0]         rsp_iter_count,
   output logic [GRAY_W-1:0]        rsp_gray_level,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_AW-1:0]        paddr,
   input  logic [CSR_DW-1:0]        pwdata,
   output logic [CSR_DW-1:0]        prdata,
   output logic                     pready
);

`include "mandelbrot_escape_time_core_assert.svh"

   logic [CNT_W-1:0]   max_iter_ff, max_iter_in;
   logic [SCALE_W-1:0] gray_scale_ff, gray_scale_in;
   logic               busy_ff, busy_in;
   logic               accept, capture, gray_ready, csr_write;
   tok_type            ring_in  [NUM_CELLS];
   tok_type            ring_out [NUM_CELLS];
   tok_type            tap, head;
   logic [NUM_CELLS-1:0] ring_valid;

   // configuration port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      max_iter_in   = max_iter_ff;
      gray_scale_in = gray_scale_ff;
      if (csr_write) begin
         case (paddr[2])
            REG_MAX_ITER:   max_iter_in   = pwdata[CNT_W-1:0];
            REG_GRAY_SCALE: gray_scale_in = pwdata[SCALE_W-1:0];
            default:        max_iter_in   = max_iter_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_MAX_ITER:   prdata = CSR_DW'(max_iter_ff);
         REG_GRAY_SCALE: prdata = CSR_DW'(gray_scale_ff);
         default:        prdata = '0;
      endcase
   end

   // request handshake
   assign req_stall = busy_ff;
   assign accept    = req_valid && !busy_ff;
   assign tap       = ring_out[NUM_CELLS-1];
   assign capture   = tap.valid && tap.done && gray_ready;

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (capture) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_iter_ff   <= MAX_ITER_RESET;
         gray_scale_ff <= GRAY_SCALE_RESET;
         busy_ff       <= 1'b0;
      end else begin
         max_iter_ff   <= max_iter_in;
         gray_scale_ff <= gray_scale_in;
         busy_ff       <= busy_in;
      end
   end

   // ring head: inject a new pixel, recirculate, or drop a captured one
   always_comb begin
      head = tap;
      if (accept) begin
         head.valid = 1'b1;
         head.done  = 1'b0;
         head.count = '0;
         head.cr    = req_c_real;
         head.ci    = req_c_imag;
         head.zr    = '0;
         head.zi    = '0;
      end else if (capture) begin
         head.valid = 1'b0;
      end
   end

   assign ring_in[0] = head;

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      if (i > 0) begin : g_link
         assign ring_in[i] = ring_out[i-1];
      end
      met_cell u_cell (
         .clock          (clock),
         .reset          (reset),
         .max_iterations (max_iter_ff),
         .tok_i          (ring_in[i]),
         .tok_o          (ring_out[i])
      );
      assign ring_valid[i] = ring_out[i].valid;
   end

   met_gray u_gray (
      .clock          (clock),
      .reset          (reset),
      .gray_scale     (gray_scale_ff),
      .in_valid       (tap.valid && tap.done),
      .in_ready       (gray_ready),
      .in_count       (tap.count),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_iter_count (rsp_iter_count),
      .rsp_gray_level (rsp_gray_level)
   );

   `MET_ASSERT_SAME(a_single_pixel, clock, reset, 1'b1, $countones(ring_valid) <= 1, "ring overfull")
   `MET_ASSERT_SAME(a_idle_ring_empty, clock, reset, !busy_ff, ring_valid == '0, "pixel while idle")
   `MET_ASSERT_NEXT(a_capture_frees, clock, reset, capture, !busy_ff, "busy after capture")

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for mandelbrot_escape_time_core: pixel requests with random
// idling on both sides, register writes between batches, fixed-point escape-time predictor.
// Depends on met_pkg and the core only.
module testbench import met_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 1530;
   localparam int CYCLE_LIMIT  = 6_000_000;
   localparam int DRAIN_CYCLES = 40;
   localparam int IDLE_PCT     = 33;
   localparam int NUM_PROBES   = 21;

   localparam logic [CSR_AW-1:0] ADDR_MAX_ITER   = {REG_MAX_ITER, 2'b00};
   localparam logic [CSR_AW-1:0] ADDR_GRAY_SCALE = {REG_GRAY_SCALE, 2'b00};

   // |z|^2 <= 4, compared on the unshifted sum of squares
   localparam logic signed [127:0] ESCAPE_R2 = 128'sd1 <<< (2 * FRAC_BITS + 2);

   typedef struct packed {
      logic [CNT_W-1:0]  cnt;
      logic [GRAY_W-1:0] gray;
   } pixel_type;

   typedef struct packed {
      logic [CNT_W-1:0]   limit;
      logic [SCALE_W-1:0] scale;
      logic [C_W-1:0]     cr;
      logic [C_W-1:0]     ci;
      logic               known;
      logic [CNT_W-1:0]   cnt;
      logic [GRAY_W-1:0]  gray;
   } probe_type;

   // Coordinates in Q4.28; rows with known clear are checked against the predictor.
   localparam probe_type PROBES [NUM_PROBES] = '{
      '{16'd255,   24'd65536,    32'h0000_0000, 32'h0000_0000, 1'b1, 16'd255,   8'd255},
      '{16'd255,   24'd65536,    32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 16'd1,     8'd1},
      '{16'd255,   24'd65536,    32'h8000_0000, 32'h8000_0000, 1'b1, 16'd1,     8'd1},
      '{16'd255,   24'd65536,    32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 16'd1,     8'd1},
      '{16'd255,   24'd65536,    32'hE000_0000, 32'h0000_0000, 1'b0, 16'd0,     8'd0},
      '{16'd255,   24'd65536,    32'h2000_0000, 32'h0000_0000, 1'b0, 16'd0,     8'd0},
      '{16'd255,   24'd65536,    32'h1000_0000, 32'h0000_0000, 1'b0, 16'd0,     8'd0},
      '{16'd255,   24'd65536,    32'h0400_0000, 32'h0000_0000, 1'b0, 16'd0,     8'd0},
      '{16'd255,   24'd65536,    32'h0000_0000, 32'h1000_0000, 1'b0, 16'd0,     8'd0},
      '{16'd255,   24'd65536,    32'hF000_0000, 32'h0000_0000, 1'b0, 16'd0,     8'd0},
      '{16'd255,   24'd65536,    32'hF400_0000, 32'h0199_999A, 1'b0, 16'd0,     8'd0},
      '{16'd0,     24'd65536,    32'h0000_0000, 32'h0000_0000, 1'b1, 16'd0,     8'd0},
      '{16'd0,     24'd65536,    32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 16'd0,     8'd0},
      '{16'd65535, 24'hFF_FFFF,  32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 16'd1,     8'd255},
      '{16'd65535, 24'hFF_FFFF,  32'h0800_0000, 32'h0800_0000, 1'b0, 16'd0,     8'd0},
      '{16'd65535, 24'd1,        32'h0000_0000, 32'h0000_0000, 1'b1, 16'd65535, 8'd1},
      '{16'd1,     24'd0,        32'h0000_0000, 32'h0000_0000, 1'b1, 16'd1,     8'd0},
      '{16'd1,     24'hFF_FFFF,  32'h8000_0000, 32'h0000_0000, 1'b1, 16'd1,     8'd255},
      '{16'd2,     24'd8355840,  32'h1000_0000, 32'h0000_0000, 1'b0, 16'd0,     8'd0},
      '{16'd16,    24'd1044480,  32'h0FFF_FFFF, 32'hF000_0001, 1'b0, 16'd0,     8'd0},
      '{16'd255,   24'd65536,    32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 16'd0,     8'd0}
   };

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_valid  = 1'b0;
   logic                  req_stall;
   logic signed [C_W-1:0] req_c_real = '0;
   logic signed [C_W-1:0] req_c_imag = '0;
   logic                  rsp_valid;
   logic                  rsp_stall  = 1'b0;
   logic [CNT_W-1:0]      rsp_iter_count;
   logic [GRAY_W-1:0]     rsp_gray_level;
   logic                  psel       = 1'b0;
   logic                  penable    = 1'b0;
   logic                  pwrite     = 1'b0;
   logic [CSR_AW-1:0]     paddr      = '0;
   logic [CSR_DW-1:0]     pwdata     = '0;
   logic [CSR_DW-1:0]     prdata;
   logic                  pready;

   logic [CNT_W-1:0]   cfg_limit = MAX_ITER_RESET;
   logic [SCALE_W-1:0] cfg_scale = GRAY_SCALE_RESET;
   pixel_type          expected_px[$];
   pixel_type          owed;
   int                 mismatches = 0;
   int                 cycles     = 0;
   logic               steady     = 1'b0;

   mandelbrot_escape_time_core i_dut (.*);

   always #2 clock = ~clock;

   function automatic pixel_type escape_pixel(input logic signed [C_W-1:0] cr,
                                              input logic signed [C_W-1:0] ci);
      logic signed [63:0]  zr, zi, cr_w, ci_w;
      logic signed [127:0] rr, ii, re, im;
      logic [40:0]         scaled;
      logic                escaped;
      int                  n;
      pixel_type           px;
      cr_w    = 64'(cr);
      ci_w    = 64'(ci);
      zr      = '0;
      zi      = '0;
      n       = 0;
      escaped = 1'b0;
      while (n < int'(cfg_limit) && !escaped) begin
         rr = 128'(zr) * 128'(zr);
         ii = 128'(zi) * 128'(zi);
         if (rr + ii > ESCAPE_R2) begin
            escaped = 1'b1;
         end else begin
            re = rr - ii;
            im = 128'(zr) * 128'(zi);
            im = im <<< 1;
            // floor shift: low 64 bits above the fraction
            zr = re[FRAC_BITS +: 64] + cr_w;
            zi = im[FRAC_BITS +: 64] + ci_w;
            n++;
         end
      end
      scaled  = 41'(n) * 41'(cfg_scale) + 41'd66;
      px.cnt  = CNT_W'(n);
      px.gray = (scaled[40:16] > 25'd255) ? 8'd255 : scaled[23:16];
      return px;
   endfunction

   function automatic void pick_point(output logic signed [C_W-1:0] cr,
                                      output logic signed [C_W-1:0] ci);
      int unsigned k;
      k = $urandom_range(0, 9);
      if (k < 6) begin
         // box round the set: real -2.25..0.75, imaginary -1.5..1.5
         cr = $signed($urandom_range(0, 32'h3000_0000)) - 32'sh2400_0000;
         ci = $signed($urandom_range(0, 32'h3000_0000)) - 32'sh1800_0000;
      end else if (k < 8) begin
         // near the boundary, where counts run long
         cr = $signed($urandom_range(0, 32'h0199_9999)) - 32'sh0CCC_CCCC;
         ci = $signed($urandom_range(0, 32'h0333_3333));
      end else begin
         cr = $urandom;
         ci = $urandom;
      end
   endfunction

   task automatic send_pixel(input logic signed [C_W-1:0] cr, input logic signed [C_W-1:0] ci,
                             input pixel_type want);
      int gaps;
      gaps = 0;
      if (!steady) begin
         while ($urandom_range(0, 99) < IDLE_PCT) gaps++;
      end
      if (gaps > 0) begin
         req_valid <= 1'b0;
         repeat (gaps) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_c_real <= cr;
      req_c_imag <= ci;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_px.push_back(want);
   endtask

   // setup then access; psel and penable are left for the caller to drop
   task automatic csr_write(input logic [CSR_AW-1:0] addr, input logic [CSR_DW-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
   endtask

   task automatic configure(input logic [CNT_W-1:0] lim, input logic [SCALE_W-1:0] scl,
                            input bit put_lim, input bit put_scl);
      req_valid <= 1'b0;
      // drain every pixel in flight before touching the registers
      while (expected_px.size() != 0) @(posedge clock);
      if (put_lim) begin
         csr_write(ADDR_MAX_ITER, CSR_DW'(lim));
         cfg_limit = lim;
      end
      if (put_scl) begin
         csr_write(ADDR_GRAY_SCALE, CSR_DW'(scl));
         cfg_scale = scl;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic note_fault(input string what);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $time, what);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_px.size() == 0) begin
            note_fault($sformatf("result count %0d gray %0d with no request outstanding",
                                 rsp_iter_count, rsp_gray_level));
         end else begin
            owed = expected_px.pop_front();
            if (rsp_iter_count !== owed.cnt || rsp_gray_level !== owed.gray)
               note_fault($sformatf("count %0d gray %0d, expected count %0d gray %0d",
                                    rsp_iter_count, rsp_gray_level, owed.cnt, owed.gray));
         end
      end
      rsp_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("mandelbrot_escape_time_core: mismatch");
         $finish;
      end
   end

   initial begin
      probe_type             row;
      pixel_type             want;
      logic signed [C_W-1:0] cr, ci;
      logic [CNT_W-1:0]      lim;
      logic [SCALE_W-1:0]    scl;
      int unsigned           pick;
      int                    sent, batch, phase;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_PROBES; i++) begin
         row = PROBES[i];
         if (row.limit != cfg_limit || row.scale != cfg_scale)
            configure(row.limit, row.scale, row.limit != cfg_limit, row.scale != cfg_scale);
         if (row.known) begin
            want.cnt  = row.cnt;
            want.gray = row.gray;
         end else begin
            want = escape_pixel(row.cr, row.ci);
         end
         send_pixel(row.cr, row.ci, want);
      end

      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0:       lim = 16'd1;
            1:       lim = CNT_W'($urandom_range(2, 8));
            2, 3,
            4, 5:    lim = CNT_W'($urandom_range(9, 64));
            6, 7:    lim = CNT_W'($urandom_range(65, 300));
            8:       lim = 16'd255;
            default: lim = 16'd0;
         endcase
         // one batch with a deep limit, kept short
         if (phase == 3) lim = CNT_W'($urandom_range(1000, 4000));
         pick = $urandom_range(0, 7);
         case (pick)
            0:       scl = '0;
            1:       scl = '1;
            2, 3:    scl = SCALE_W'($urandom_range(0, 24'hFF_FFFF));
            default: scl = (lim != 0) ? SCALE_W'(32'd16711680 / lim) : GRAY_SCALE_RESET;
         endcase
         configure(lim, scl, phase == 0 || phase == 3 || $urandom_range(0, 3) != 0,
                   phase == 0 || $urandom_range(0, 3) != 0);
         batch = (phase == 3) ? 12 : $urandom_range(30, 110);
         for (int k = 0; k < batch && sent < RANDOM_ITEMS; k++) begin
            // hold both sides busy for a stretch
            steady <= (sent >= 500 && sent < 800);
            pick_point(cr, ci);
            send_pixel(cr, ci, escape_pixel(cr, ci));
            sent++;
         end
         phase++;
      end

      req_valid <= 1'b0;
      while (expected_px.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("mandelbrot_escape_time_core: match");
      end else begin
         $display("mandelbrot_escape_time_core: mismatch");
      end
      $finish;
   end

endmodule
